// ===== sv/ordt_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ordt_pkg
// Shared item types, operation and status codes for the ordered array table.
// ============================================================================
package ordt_pkg;

    // Operation codes carried in the func field.
    localparam logic [1:0] FUNC_INS  = 2'd0;
    localparam logic [1:0] FUNC_DEL  = 2'd1;
    localparam logic [1:0] FUNC_SRCH = 2'd2;

    // Result status codes.
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_FULL   = 2'd1;
    localparam logic [1:0] STAT_BADPOS = 2'd2;

    typedef struct packed {
        logic [1:0]         func;
        logic [5:0]         position;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic               found;
        logic [5:0]         found_index;
        logic [5:0]         entry_count;
        logic signed [31:0] min_value;
        logic signed [31:0] max_value;
    } t_out_item;

    // Control from the sequencer to the scan accumulator.
    typedef struct packed {
        logic clear;
        logic load;
        logic search;
    } t_scan_ctl;

endpackage

// ===== sv/ordered_array_table_engine.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ordered_array_table_engine
// Packed ordered table of signed entries with insert, delete and search.
// ============================================================================
// The block holds up to DEPTH signed 32-bit entries, packed from address 0, in
// a single-port-read, single-port-write memory, plus a count of the entries
// held. Each input item is an insert at a 1-based position, a delete at a
// 1-based position, or a search for a key, and each item yields exactly one
// result item with the status, the search outcome, the new count and the
// minimum and maximum of the contents. The block works on one item at a
// time. An insert walks the memory once to move entries up, one entry per
// cycle, then writes the new value; a delete walks it to move entries down.
// After every operation a scan reads all held entries, one per cycle through
// the memory read port, to build the minimum and maximum and, for a search,
// the first matching index. The result becomes valid in the same cycle as
// the input is free again.
// A full table on insert or a position out of range leaves the store alone
// and is reported in the status; unknown operation codes report ok. The input
// is stalled while an item is in progress; a finished result waits in the
// output register while the next item may already be accepted.
// ============================================================================
module ordered_array_table_engine #(
    parameter int DEPTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  ordt_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output ordt_pkg::t_out_item  o_out_item
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = ((CW > 6) ? CW : 6) + 1;

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SHUP = 3'd1;
    localparam logic [2:0] S_SHDN = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    // Control registers.
    logic [2:0]          r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic                r_issue, n_issue;
    logic                r_pend,  n_pend;
    logic                r_out_valid, n_out_valid;

    // Payload registers.
    logic [1:0]          r_func, n_func;
    logic [1:0]          r_status, n_status;
    logic signed [31:0]  r_key, n_key;
    logic [AW-1:0]       r_stop, n_stop;
    logic [AW-1:0]       r_rd_addr, n_rd_addr;
    logic [AW-1:0]       r_pend_addr, n_pend_addr;
    ordt_pkg::t_out_item r_out_item, n_out_item;

    // Memory and scan connections.
    logic                mem_rd_en;
    logic                mem_wr_en;
    logic [AW-1:0]       mem_wr_addr;
    logic signed [31:0]  mem_wr_data;
    logic signed [31:0]  mem_rd_data;
    ordt_pkg::t_scan_ctl scan_ctl;
    logic signed [31:0]  scan_min;
    logic signed [31:0]  scan_max;
    logic                scan_found;
    logic [CW-1:0]       scan_found_index;

    logic                in_accept;
    logic                go_scan;
    logic [WW-1:0]       pos_w;
    logic [WW-1:0]       cnt_w;

    assign in_accept = i_in_valid && !o_in_stall;
    assign pos_w     = WW'(i_in_item.position);
    assign cnt_w     = WW'(r_count);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_issue     = r_issue;
        n_pend      = r_pend;
        n_out_valid = r_out_valid;
        n_func      = r_func;
        n_status    = r_status;
        n_key       = r_key;
        n_stop      = r_stop;
        n_rd_addr   = r_rd_addr;
        n_pend_addr = r_pend_addr;
        n_out_item  = r_out_item;
        mem_rd_en   = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_pend_addr;
        mem_wr_data = mem_rd_data;
        scan_ctl    = '0;
        go_scan     = 1'b0;

        // The waiting result leaves once the consumer takes it.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_func   = i_in_item.func;
                    n_key    = i_in_item.value;
                    n_status = ordt_pkg::STAT_OK;
                    n_issue  = 1'b0;
                    n_pend   = 1'b0;
                    case (i_in_item.func)
                        ordt_pkg::FUNC_INS: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_status = ordt_pkg::STAT_FULL;
                                go_scan  = 1'b1;
                            end else if ((pos_w == '0) || (pos_w > cnt_w + WW'(1))) begin
                                n_status = ordt_pkg::STAT_BADPOS;
                                go_scan  = 1'b1;
                            end else begin
                                // Slot of the new value; entries from there on move up.
                                n_stop    = AW'(pos_w - WW'(1));
                                n_rd_addr = AW'(r_count - CW'(1));
                                n_issue   = (pos_w <= cnt_w);
                                n_state   = S_SHUP;
                            end
                        end
                        ordt_pkg::FUNC_DEL: begin
                            if ((pos_w == '0) || (pos_w > cnt_w)) begin
                                n_status = ordt_pkg::STAT_BADPOS;
                                go_scan  = 1'b1;
                            end else begin
                                // Entries after the deleted one move down.
                                n_rd_addr = AW'(pos_w);
                                n_stop    = AW'(r_count - CW'(1));
                                n_issue   = (pos_w < cnt_w);
                                n_state   = S_SHDN;
                            end
                        end
                        default: begin
                            go_scan = 1'b1;
                        end
                    endcase
                end
            end

            S_SHUP: begin
                // Read entry k, write it to k+1 in the following cycle.
                if (r_issue) begin
                    mem_rd_en   = 1'b1;
                    n_pend      = 1'b1;
                    n_pend_addr = r_rd_addr + AW'(1);
                    if (r_rd_addr == r_stop) begin
                        n_issue = 1'b0;
                    end else begin
                        n_rd_addr = r_rd_addr - AW'(1);
                    end
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    mem_wr_en = 1'b1;
                end
                if (!r_issue && !r_pend) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = r_stop;
                    mem_wr_data = r_key;
                    n_count     = r_count + CW'(1);
                    go_scan     = 1'b1;
                end
            end

            S_SHDN: begin
                // Read entry k, write it to k-1 in the following cycle.
                if (r_issue) begin
                    mem_rd_en   = 1'b1;
                    n_pend      = 1'b1;
                    n_pend_addr = r_rd_addr - AW'(1);
                    if (r_rd_addr == r_stop) begin
                        n_issue = 1'b0;
                    end else begin
                        n_rd_addr = r_rd_addr + AW'(1);
                    end
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    mem_wr_en = 1'b1;
                end
                if (!r_issue && !r_pend) begin
                    n_count = r_count - CW'(1);
                    go_scan = 1'b1;
                end
            end

            S_SCAN: begin
                scan_ctl.search = (r_func == ordt_pkg::FUNC_SRCH);
                if (r_issue) begin
                    mem_rd_en   = 1'b1;
                    n_pend      = 1'b1;
                    n_pend_addr = r_rd_addr;
                    if (r_rd_addr == AW'(r_count - CW'(1))) begin
                        n_issue = 1'b0;
                    end else begin
                        n_rd_addr = r_rd_addr + AW'(1);
                    end
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    scan_ctl.load = 1'b1;
                end
                if (!r_issue && !r_pend) begin
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid             = 1'b1;
                    n_out_item.status       = r_status;
                    n_out_item.found        = scan_found;
                    n_out_item.found_index  = 6'(scan_found_index);
                    n_out_item.entry_count  = 6'(r_count);
                    n_out_item.min_value    = scan_min;
                    n_out_item.max_value    = scan_max;
                    n_state                 = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Every operation ends with a pass over the held entries.
        if (go_scan) begin
            n_state        = S_SCAN;
            n_rd_addr      = '0;
            n_issue        = (n_count != '0);
            n_pend         = 1'b0;
            scan_ctl.clear = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_issue     <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_issue     <= n_issue;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func      <= n_func;
        r_status    <= n_status;
        r_key       <= n_key;
        r_stop      <= n_stop;
        r_rd_addr   <= n_rd_addr;
        r_pend_addr <= n_pend_addr;
        r_out_item  <= n_out_item;
    end

    ordt_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (r_rd_addr),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .o_rd_data (mem_rd_data)
    );

    ordt_scan #(
        .DEPTH (DEPTH)
    ) u_scan (
        .i_clk         (i_clk),
        .i_ctl         (scan_ctl),
        .i_index       (r_pend_addr),
        .i_data        (mem_rd_data),
        .i_key         (r_key),
        .o_min         (scan_min),
        .o_max         (scan_max),
        .o_found       (scan_found),
        .o_found_index (scan_found_index)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== sv/ordt_mem.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ordt_mem
// Entry store: one write port, one read port with registered read data.
// ============================================================================
module ordt_mem #(
    parameter int DEPTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    input  logic                       i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  logic signed [31:0]         i_wr_data,
    output logic signed [31:0]         o_rd_data
);

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/ordt_scan.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ordt_scan
// Running minimum, maximum and first-match search over streamed entries.
// ============================================================================
module ordt_scan #(
    parameter int DEPTH = 32
) (
    input  logic                             i_clk,
    input  ordt_pkg::t_scan_ctl              i_ctl,
    input  logic [$clog2(DEPTH)-1:0]         i_index,
    input  logic signed [31:0]               i_data,
    input  logic signed [31:0]               i_key,
    output logic signed [31:0]               o_min,
    output logic signed [31:0]               o_max,
    output logic                             o_found,
    output logic [$clog2(DEPTH+1)-1:0]       o_found_index
);

    localparam int CW = $clog2(DEPTH + 1);

    logic signed [31:0] r_min;
    logic signed [31:0] r_max;
    logic               r_found;
    logic [CW-1:0]      r_found_index;
    logic               r_first;

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_min         <= '0;
            r_max         <= '0;
            r_found       <= 1'b0;
            r_found_index <= '0;
            r_first       <= 1'b1;
        end else if (i_ctl.load) begin
            r_first <= 1'b0;
            if (r_first || (i_data < r_min)) begin
                r_min <= i_data;
            end
            if (r_first || (i_data > r_max)) begin
                r_max <= i_data;
            end
            // Only the first matching entry counts.
            if (i_ctl.search && !r_found && (i_data == i_key)) begin
                r_found       <= 1'b1;
                r_found_index <= CW'(i_index) + CW'(1);
            end
        end
    end

    assign o_min         = r_min;
    assign o_max         = r_max;
    assign o_found       = r_found;
    assign o_found_index = r_found_index;

endmodule
